// File: design/etfi_pkg.sv
// Shared types and constants for the escape-time fractal iterator.
// Used by etfi_ctrl, etfi_dp and escape_time_fractal_iterator; no dependencies.
package etfi_pkg;

    // default parameter values
    localparam int FRAC_BITS_DEF  = 28;
    localparam int COUNT_BITS_DEF = 16;

    // widths fixed by the field definitions
    localparam int PART_W    = 32;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 66;
    localparam int KIND_W    = 2;
    localparam int ITER_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KIND     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONST_RE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONST_IM = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 8'd3;

    // fractal kinds
    localparam logic [KIND_W-1:0] KIND_MANDEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_JULIA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SHIP   = 2'd2;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd256;

    // multiplier operation selects
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_RR   = 2'd1;  // re * re
    localparam logic [1:0] OP_II   = 2'd2;  // im * im
    localparam logic [1:0] OP_RI   = 2'd3;  // re * im (abs for burning ship)

    // controller to datapath
    typedef struct packed {
        logic       load;    // capture point, set up z, k, bound, limit
        logic [1:0] op;      // multiplier operation this cycle
        logic       update;  // write new z, bump the count
        logic       emit;    // present the count on the result port
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic finish;        // escaped or at the iteration limit
    } t_dp_status;

    // clamp a wide signed sum to the 32-bit signed range
    function automatic logic signed [PART_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7FFF_FFFF);
        lo = -(SUM_W'(33'sh0_8000_0000));
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[PART_W-1:0];
    endfunction

endpackage

// File: design/etfi_ctrl.sv
// Controller state machine for the escape-time fractal iterator.
// Depends on etfi_pkg; drives etfi_dp through t_dp_cmd.
module etfi_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  etfi_pkg::t_dp_status i_status,
    output etfi_pkg::t_dp_cmd    o_cmd
);
    import etfi_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MRR  = 3'd1;
    localparam logic [2:0] S_MII  = 3'd2;
    localparam logic [2:0] S_MRI  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // one iteration: three multiplies then the update / escape decision
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.op     = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MRR;
                end
            end
            S_MRR: begin
                o_cmd.op = OP_RR;
                n_state  = S_MII;
            end
            S_MII: begin
                o_cmd.op = OP_II;
                n_state  = S_MRI;
            end
            S_MRI: begin
                o_cmd.op = OP_RI;
                n_state  = S_UPD;
            end
            S_UPD: begin
                if (i_status.finish) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.update = 1'b1;
                    n_state      = S_MRR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: design/etfi_dp.sv
// Datapath for the escape-time fractal iterator: config registers, z/k state,
// one shared 32x32 multiplier, escape test, saturating update, result register.
// Depends on etfi_pkg; commanded by etfi_ctrl.
module etfi_dp #(
    parameter int FRAC_BITS  = etfi_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = etfi_pkg::COUNT_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [etfi_pkg::CFG_IDX_W-1:0]              i_cfg_idx,
    input  logic [etfi_pkg::CFG_DAT_W-1:0]              i_cfg_data,
    input  logic signed [etfi_pkg::PART_W-1:0]          i_point_re,
    input  logic signed [etfi_pkg::PART_W-1:0]          i_point_im,
    input  etfi_pkg::t_dp_cmd                           i_cmd,
    output etfi_pkg::t_dp_status                        o_status,
    output logic                                        o_valid,
    output logic [etfi_pkg::ITER_W-1:0]                 o_iteration_count
);
    import etfi_pkg::*;

    localparam int LW = (COUNT_BITS > ITER_W) ? COUNT_BITS : ITER_W;
    localparam logic [LW-1:0] CMAX = LW'({COUNT_BITS{1'b1}});
    localparam logic signed [SUM_W-1:0] BOUND4 = SUM_W'(4) <<< FRAC_BITS;
    localparam logic signed [SUM_W-1:0] BOUND3 = SUM_W'(3) <<< FRAC_BITS;

    // configuration registers
    logic [KIND_W-1:0]        r_kind;
    logic signed [PART_W-1:0] r_const_re;
    logic signed [PART_W-1:0] r_const_im;
    logic [ITER_W-1:0]        r_max_iter;

    // iteration state
    logic signed [PART_W-1:0] r_zr;
    logic signed [PART_W-1:0] r_zi;
    logic signed [PART_W-1:0] r_kr;
    logic signed [PART_W-1:0] r_ki;
    logic                     r_julia;
    logic                     r_ship;
    logic [COUNT_BITS-1:0]    r_count;
    logic [COUNT_BITS-1:0]    r_limit;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_sr;
    logic signed [PROD_W-1:0] r_si;
    logic                     r_valid;
    logic [ITER_W-1:0]        r_out;

    logic signed [PART_W-1:0] w_mul_a;
    logic signed [PART_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_cross;
    logic signed [SUM_W-1:0]  w_mag;
    logic signed [SUM_W-1:0]  w_new_re;
    logic signed [SUM_W-1:0]  w_new_im;
    logic                     w_escape;
    logic                     w_at_limit;
    logic                     w_julia_in;
    logic                     w_ship_in;
    logic [LW-1:0]            w_max_ext;
    logic [COUNT_BITS-1:0]    w_limit_in;

    // abs with the most negative value clamped to the positive maximum
    function automatic logic signed [PART_W-1:0] abs_sat(input logic signed [PART_W-1:0] v);
        if (v == 32'sh8000_0000) begin
            return 32'sh7FFF_FFFF;
        end
        return (v < 0) ? -v : v;
    endfunction

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= KIND_MANDEL;
            r_const_re <= '0;
            r_const_im <= '0;
            r_max_iter <= MAX_ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KIND:     r_kind     <= i_cfg_data[KIND_W-1:0];
                REG_CONST_RE: r_const_re <= i_cfg_data[PART_W-1:0];
                REG_CONST_IM: r_const_im <= i_cfg_data[PART_W-1:0];
                REG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // setup values for a new point
    assign w_julia_in = (r_kind == KIND_JULIA);
    assign w_ship_in  = (r_kind == KIND_SHIP);
    assign w_max_ext  = LW'(r_max_iter);
    assign w_limit_in = COUNT_BITS'((w_max_ext > CMAX) ? CMAX : w_max_ext);

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_RR: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
            OP_II: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            OP_RI: begin
                w_mul_a = r_ship ? abs_sat(r_zr) : r_zr;
                w_mul_b = r_ship ? abs_sat(r_zi) : r_zi;
            end
            default: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // escape test and next z from the registered products
    assign w_cross    = r_prod >>> (FRAC_BITS - 1);
    assign w_mag      = SUM_W'(r_sr) + SUM_W'(r_si);
    assign w_escape   = (w_mag >= (r_julia ? BOUND3 : BOUND4));
    assign w_at_limit = (r_count == r_limit);
    assign w_new_re   = SUM_W'(r_sr) - SUM_W'(r_si) + SUM_W'(r_kr);
    assign w_new_im   = SUM_W'(w_cross) + SUM_W'(r_ki);

    assign o_status.finish = w_escape || w_at_limit;

    // z, k and per-point setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_julia <= w_julia_in;
            r_ship  <= w_ship_in;
            r_limit <= w_limit_in;
            if (w_julia_in) begin
                r_zr <= i_point_re;
                r_zi <= i_point_im;
                r_kr <= r_const_re;
                r_ki <= r_const_im;
            end else begin
                r_zr <= sat32(SUM_W'(i_point_re) + SUM_W'(r_const_re));
                r_zi <= sat32(SUM_W'(i_point_im) + SUM_W'(r_const_im));
                r_kr <= i_point_re;
                r_ki <= i_point_im;
            end
        end else if (i_cmd.update) begin
            r_zr <= sat32(w_new_re);
            r_zi <= sat32(w_new_im);
        end
    end

    // product register and scaled squares
    always_ff @(posedge i_clk) begin
        if (i_cmd.op != OP_NONE) begin
            r_prod <= w_prod;
        end
        if (i_cmd.op == OP_II) begin
            r_sr <= r_prod >>> FRAC_BITS;
        end
        if (i_cmd.op == OP_RI) begin
            r_si <= r_prod >>> FRAC_BITS;
        end
    end

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_count <= r_count + 1'b1;
        end
    end

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_out <= ITER_W'(LW'(r_count));
        end
    end

    assign o_valid           = r_valid;
    assign o_iteration_count = r_out;

endmodule

// File: design/escape_time_fractal_iterator.sv
// Top level of the escape-time fractal iterator (Mandelbrot, Julia, burning ship).
// Depends on etfi_pkg, etfi_ctrl and etfi_dp.
//
//  channel   | ports                                       | transfer when
//  ----------+---------------------------------------------+----------------------
//  point in  | start, busy, i_point_re, i_point_im         | start high, busy low
//  count out | o_valid, o_iteration_count                  | o_valid high (1 cycle)
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data             | i_cfg_we high
//
// After the accepting edge, each escape check runs three products through the
// single shared 32x32 multiplier and then an update step; the result strobe
// follows the last check. busy drops in the strobe cycle, so the next point can
// be taken at the edge that ends it. Reset (synchronous, active low) restores
// the register defaults and idles the controller. The result strobe is high for
// exactly one cycle; the receiver cannot stall it.
module escape_time_fractal_iterator #(
    parameter int FRAC_BITS  = etfi_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = etfi_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [etfi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [etfi_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [etfi_pkg::PART_W-1:0] i_point_re,
    input  logic signed [etfi_pkg::PART_W-1:0] i_point_im,
    output logic                               o_valid,
    output logic [etfi_pkg::ITER_W-1:0]        o_iteration_count
);
    import etfi_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    etfi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    etfi_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_point_re        (i_point_re),
        .i_point_im        (i_point_im),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_valid           (o_valid),
        .o_iteration_count (o_iteration_count)
    );

endmodule
